### rtl/csc_pkg.sv
// Package for the color space converter: command codes, transfer payload types
// and the divider and pipeline constants.
// Has no dependencies of its own.
package csc_pkg;

    typedef enum logic [1:0] {
        CMD_RGB2HSV = 2'd0,
        CMD_HSV2RGB = 2'd1,
        CMD_RGB2HLS = 2'd2,
        CMD_HLS2RGB = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] chan_a;
        logic [7:0] chan_b;
        logic [7:0] chan_c;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_a;
        logic [7:0] out_b;
        logic [7:0] out_c;
    } t_out_item;

    // Side information that travels alongside the divider lanes.
    typedef struct packed {
        t_cmd       command;
        logic       shortcut;
        logic [7:0] sc_val;
        logic [7:0] mx;
        logic [7:0] half_sum;
        logic [2:0] sec;
    } t_side;

    localparam int NUM_W      = 24;
    localparam int DEN_W      = 16;
    localparam int Q_W        = 8;
    localparam int LANES      = 3;
    localparam int DIV_STAGES = 4;
    localparam int DIV_BITS   = Q_W / DIV_STAGES;

    localparam logic [15:0] HSV_DEN_SQ = 16'd65025;
    localparam logic [15:0] HLS_DEN    = 16'd21675;

endpackage

### rtl/color_space_converter.sv
// Color space converter top level: RGB to/from HSV and HLS, one pixel per clock.
// Depends on csc_pkg for the payload types, command codes and divider constants.
//
// Usage:
// The input channel (i_valid, o_stall, i_data) carries one pixel and a command per
// transfer. The output channel (o_valid, i_stall, o_data) returns one converted
// pixel per input transfer, in order. Hue is scaled to 0..255.
// The pipeline is eight register stages deep. Throughput is one pixel per clock
// while the receiver does not stall; it is set by the restoring divider, three
// lanes wide, that resolves two quotient bits in each of its four stages.
// The stages are an input register, a min/max and product stage, a numerator
// stage, four divider stages and the output register.
// Each stage holds its own valid bit and advances whenever the stage after it is
// empty or advancing, so bubbles are squeezed out while the receiver stalls.
// o_stall rises only once every stage is full and i_stall is high; a stalled
// result holds its value. A synchronous active-low reset empties the pipeline.
module color_space_converter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  csc_pkg::t_in_item   i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output csc_pkg::t_out_item  o_data
);

    localparam int NSTG = csc_pkg::DIV_STAGES + 4;

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !r_v[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (en[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    function automatic logic [6:0] hls_k(input logic [7:0] h);
        logic [8:0] dn;
        dn = 9'd340 - {h, 1'b0};
        if (h <= 8'd42) begin
            hls_k = {h[5:0], 1'b0};
        end else if (h <= 8'd127) begin
            hls_k = 7'd85;
        end else if (h < 8'd170) begin
            hls_k = dn[6:0];
        end else begin
            hls_k = 7'd0;
        end
    endfunction

    // Input register.
    csc_pkg::t_in_item r_in;
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_in <= i_data;
        end
    end

    // Stage 1: extremes, hue sector, narrow products and hue ramp weights.
    logic [7:0]  s_a, s_b, s_c, n1_mx, n1_mn, n1_f;
    logic [10:0] sixa, f_full;
    logic [2:0]  sec_raw;
    logic [7:0]  ha0, ha2;
    logic [1:0]  n1_maxsel;

    always_comb begin
        s_a = r_in.chan_a;
        s_b = r_in.chan_b;
        s_c = r_in.chan_c;
        n1_mx = s_a;
        if (s_b > n1_mx) n1_mx = s_b;
        if (s_c > n1_mx) n1_mx = s_c;
        n1_mn = s_a;
        if (s_b < n1_mn) n1_mn = s_b;
        if (s_c < n1_mn) n1_mn = s_c;
        if (s_a == n1_mx) begin
            n1_maxsel = 2'd0;
        end else if (s_b == n1_mx) begin
            n1_maxsel = 2'd1;
        end else begin
            n1_maxsel = 2'd2;
        end
        sixa = 11'(s_a) * 11'd6;
        if (sixa >= 11'd1530) sec_raw = 3'd6;
        else if (sixa >= 11'd1275) sec_raw = 3'd5;
        else if (sixa >= 11'd1020) sec_raw = 3'd4;
        else if (sixa >= 11'd765) sec_raw = 3'd3;
        else if (sixa >= 11'd510) sec_raw = 3'd2;
        else if (sixa >= 11'd255) sec_raw = 3'd1;
        else sec_raw = 3'd0;
        f_full = sixa - 11'(sec_raw) * 11'd255;
        n1_f = f_full[7:0];
        ha0 = (s_a > 8'd170) ? s_a - 8'd170 : s_a + 8'd85;
        ha2 = (s_a >= 8'd85) ? s_a - 8'd85 : s_a + 8'd170;
    end

    csc_pkg::t_cmd r1_cmd;
    logic [7:0]  r1_a, r1_b, r1_c, r1_mx, r1_delta;
    logic [8:0]  r1_sum;
    logic [1:0]  r1_maxsel;
    logic [2:0]  r1_sec;
    logic [15:0] r1_sf, r1_sg, r1_ls;
    logic [6:0]  r1_k [csc_pkg::LANES];

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_cmd    <= r_in.command;
            r1_a      <= s_a;
            r1_b      <= s_b;
            r1_c      <= s_c;
            r1_mx     <= n1_mx;
            r1_delta  <= n1_mx - n1_mn;
            r1_sum    <= 9'(n1_mx) + 9'(n1_mn);
            r1_maxsel <= n1_maxsel;
            r1_sec    <= (sec_raw == 3'd6) ? 3'd0 : sec_raw;
            r1_sf     <= 16'(s_b) * 16'(n1_f);
            r1_sg     <= 16'(s_b) * 16'(8'd255 - n1_f);
            r1_ls     <= 16'(s_b) * 16'(s_c);
            r1_k[0]   <= hls_k(ha0);
            r1_k[1]   <= hls_k(s_a);
            r1_k[2]   <= hls_k(ha2);
        end
    end

    // Stage 2: numerators and denominators of the three divider lanes.
    logic [19:0] hx, hn, hw, d510;
    logic [16:0] ls2, dm;
    logic [17:0] m1;
    logic [8:0]  sden;
    logic [csc_pkg::NUM_W-1:0] n2_num [csc_pkg::LANES];
    logic [csc_pkg::DEN_W-1:0] n2_den [csc_pkg::LANES];
    csc_pkg::t_side n2_side;

    always_comb begin
        case (r1_maxsel)
            2'd0:    hx = 20'(r1_b) - 20'(r1_c);
            2'd1:    hx = 20'({r1_delta, 1'b0}) + 20'(r1_c) - 20'(r1_a);
            default: hx = 20'({r1_delta, 2'b0}) + 20'(r1_a) - 20'(r1_b);
        endcase
        hn   = hx * 20'd85;
        d510 = 20'(r1_delta) * 20'd510;
        hw   = hn[19] ? hn + d510 : hn;
        sden = (r1_sum < 9'd256) ? r1_sum : 9'd511 - r1_sum;
        ls2  = {r1_ls, 1'b0};
        if (!r1_b[7]) begin
            dm = ls2;
            m1 = 18'(r1_b) * 18'd255 - 18'(r1_ls);
        end else begin
            dm = 17'(r1_c) * 17'd510 - ls2;
            m1 = 18'(r1_b) * 18'd255 + 18'(r1_ls) - 18'(r1_c) * 18'd255;
        end

        n2_side.command  = r1_cmd;
        n2_side.mx       = r1_mx;
        n2_side.half_sum = r1_sum[8:1];
        n2_side.sec      = r1_sec;
        case (r1_cmd)
            csc_pkg::CMD_HSV2RGB: begin
                n2_side.shortcut = (r1_b == 8'd0);
                n2_side.sc_val   = r1_c;
                n2_num[0] = 24'(r1_c) * 24'(8'd255 - r1_b);
                n2_den[0] = 16'd255;
                n2_num[1] = 24'(r1_c) * 24'(csc_pkg::HSV_DEN_SQ - r1_sf);
                n2_den[1] = csc_pkg::HSV_DEN_SQ;
                n2_num[2] = 24'(r1_c) * 24'(csc_pkg::HSV_DEN_SQ - r1_sg);
                n2_den[2] = csc_pkg::HSV_DEN_SQ;
            end
            csc_pkg::CMD_HLS2RGB: begin
                n2_side.shortcut = (r1_c == 8'd0);
                n2_side.sc_val   = r1_b;
                for (int l = 0; l < csc_pkg::LANES; l++) begin
                    n2_num[l] = 24'(m1) * 24'd85 + 24'(dm) * 24'(r1_k[l]);
                    n2_den[l] = csc_pkg::HLS_DEN;
                end
            end
            default: begin
                n2_side.shortcut = (r1_delta == 8'd0);
                n2_side.sc_val   = r1_mx;
                n2_num[0] = 24'(hw);
                n2_den[0] = 16'({r1_delta, 1'b0});
                n2_num[1] = 24'(r1_delta) * 24'd255;
                n2_den[1] = (r1_cmd == csc_pkg::CMD_RGB2HSV) ? 16'(r1_mx) : 16'(sden);
                n2_num[2] = '0;
                n2_den[2] = '0;
            end
        endcase
    end

    logic [csc_pkg::NUM_W-1:0] r2_num [csc_pkg::LANES];
    logic [csc_pkg::DEN_W-1:0] r2_den [csc_pkg::LANES];
    csc_pkg::t_side r2_side;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_num  <= n2_num;
            r2_den  <= n2_den;
            r2_side <= n2_side;
        end
    end

    // Stages 3 to 6: restoring divider, two quotient bits per stage.
    logic [csc_pkg::NUM_W-1:0] r_drem [csc_pkg::DIV_STAGES][csc_pkg::LANES];
    logic [csc_pkg::DEN_W-1:0] r_dden [csc_pkg::DIV_STAGES][csc_pkg::LANES];
    logic [csc_pkg::Q_W-1:0]   r_dq   [csc_pkg::DIV_STAGES][csc_pkg::LANES];
    csc_pkg::t_side            r_dside [csc_pkg::DIV_STAGES];
    logic [csc_pkg::NUM_W-1:0] n_drem [csc_pkg::DIV_STAGES][csc_pkg::LANES];
    logic [csc_pkg::Q_W-1:0]   n_dq   [csc_pkg::DIV_STAGES][csc_pkg::LANES];

    always_comb begin
        logic [csc_pkg::NUM_W-1:0] rem;
        logic [csc_pkg::NUM_W-1:0] trial;
        logic [csc_pkg::Q_W-1:0]   q;
        for (int g = 0; g < csc_pkg::DIV_STAGES; g++) begin
            for (int l = 0; l < csc_pkg::LANES; l++) begin
                rem = (g == 0) ? r2_num[l] : r_drem[(g == 0) ? 0 : g - 1][l];
                q   = (g == 0) ? '0 : r_dq[(g == 0) ? 0 : g - 1][l];
                for (int bb = 0; bb < csc_pkg::DIV_BITS; bb++) begin
                    trial = csc_pkg::NUM_W'((g == 0) ? r2_den[l]
                                                     : r_dden[(g == 0) ? 0 : g - 1][l])
                            << (csc_pkg::Q_W - 1 - csc_pkg::DIV_BITS * g - bb);
                    if (rem >= trial) begin
                        rem = rem - trial;
                        q   = {q[csc_pkg::Q_W-2:0], 1'b1};
                    end else begin
                        q   = {q[csc_pkg::Q_W-2:0], 1'b0};
                    end
                end
                n_drem[g][l] = rem;
                n_dq[g][l]   = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < csc_pkg::DIV_STAGES; g++) begin
            if (en[g+3]) begin
                r_drem[g] <= n_drem[g];
                r_dq[g]   <= n_dq[g];
                if (g == 0) begin
                    r_dden[g]  <= r2_den;
                    r_dside[g] <= r2_side;
                end else begin
                    r_dden[g]  <= r_dden[(g == 0) ? 0 : g - 1];
                    r_dside[g] <= r_dside[(g == 0) ? 0 : g - 1];
                end
            end
        end
    end

    // Output stage: pick results per command and hue sector.
    csc_pkg::t_out_item n_out, r_out;
    csc_pkg::t_side     fs;
    logic [7:0]         q0, q1, q2;

    always_comb begin
        fs = r_dside[csc_pkg::DIV_STAGES-1];
        q0 = r_dq[csc_pkg::DIV_STAGES-1][0];
        q1 = r_dq[csc_pkg::DIV_STAGES-1][1];
        q2 = r_dq[csc_pkg::DIV_STAGES-1][2];
        case (fs.command)
            csc_pkg::CMD_RGB2HSV: begin
                n_out.out_a = fs.shortcut ? 8'd0 : q0;
                n_out.out_b = fs.shortcut ? 8'd0 : q1;
                n_out.out_c = fs.mx;
            end
            csc_pkg::CMD_RGB2HLS: begin
                n_out.out_a = fs.shortcut ? 8'd0 : q0;
                n_out.out_b = fs.half_sum;
                n_out.out_c = fs.shortcut ? 8'd0 : q1;
            end
            csc_pkg::CMD_HSV2RGB: begin
                if (fs.shortcut) begin
                    n_out = '{fs.sc_val, fs.sc_val, fs.sc_val};
                end else begin
                    case (fs.sec)
                        3'd0:    n_out = '{fs.sc_val, q2, q0};
                        3'd1:    n_out = '{q1, fs.sc_val, q0};
                        3'd2:    n_out = '{q0, fs.sc_val, q2};
                        3'd3:    n_out = '{q0, q1, fs.sc_val};
                        3'd4:    n_out = '{q2, q0, fs.sc_val};
                        default: n_out = '{fs.sc_val, q0, q1};
                    endcase
                end
            end
            default: begin
                if (fs.shortcut) begin
                    n_out = '{fs.sc_val, fs.sc_val, fs.sc_val};
                end else begin
                    n_out = '{q0, q1, q2};
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[NSTG-1]) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

endmodule

### rtl/csc_checker.sv
// Port-level checker for the color space converter, bound to the top level.
// Depends on csc_pkg for the output payload type.
module csc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input csc_pkg::t_out_item o_data
);

    // A result held by the receiver stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled output transfer changed");

    // The block only pushes back when its output is full and stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stall without a stalled output");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

    // With the receiver free, a stall on the input side does not persist.
    a_stall_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall && !i_stall |=> !o_stall)
        else $error("input stall persists with a free receiver");

    // An idle input cannot raise the stall.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall && !i_valid |=> !o_stall)
        else $error("stall raised without a new transfer");

endmodule

bind color_space_converter csc_checker u_csc_checker (.*);
